// ===== hdl/heightmap_layer_blend_macros.svh =====
// assertion helpers shared by the blend pipeline
`ifndef HEIGHTMAP_LAYER_BLEND_MACROS_SVH
`define HEIGHTMAP_LAYER_BLEND_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HLB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define HLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/hlb_pkg.sv =====
package hlb_pkg;

   localparam int FRAC_BITS_DEFAULT = 15;
   localparam int SAMPLE_W          = 16;
   localparam int MODE_W            = 3;
   localparam int CSR_ADDR_W        = 4;
   localparam int CSR_DATA_W        = 32;

   // blend modes
   localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUBTRACT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SCREEN   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_MAX      = 3'd5;
   localparam logic [MODE_W-1:0] MODE_MIN      = 3'd6;
   localparam logic [MODE_W-1:0] MODE_OVERLAY  = 3'd7;

   // register word indexes (byte address / 4)
   localparam logic [1:0] REG_BLEND_MODE    = 2'd0;
   localparam logic [1:0] REG_LAYER_OPACITY = 2'd1;
   localparam logic [1:0] REG_MASK_ENABLE   = 2'd2;

   localparam logic [MODE_W-1:0]   BLEND_MODE_RESET    = MODE_NORMAL;
   localparam logic [SAMPLE_W-1:0] LAYER_OPACITY_RESET = 16'd32768;
   localparam logic                MASK_ENABLE_RESET   = 1'b0;

   typedef struct packed {
      logic [MODE_W-1:0]   blend_mode;
      logic [SAMPLE_W-1:0] layer_opacity;
      logic                mask_enable;
   } cfg_type;

endpackage

// ===== hdl/hlb_csr.sv =====
module hlb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hlb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [hlb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [hlb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output hlb_pkg::cfg_type                    cfg
);

   hlb_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // byte offset bits are ignored
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            hlb_pkg::REG_BLEND_MODE: begin
               cfg_in.blend_mode = csr_pwdata[hlb_pkg::MODE_W-1:0];
            end
            hlb_pkg::REG_LAYER_OPACITY: begin
               cfg_in.layer_opacity = csr_pwdata[hlb_pkg::SAMPLE_W-1:0];
            end
            hlb_pkg::REG_MASK_ENABLE: begin
               cfg_in.mask_enable = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         hlb_pkg::REG_BLEND_MODE: begin
            csr_prdata = hlb_pkg::CSR_DATA_W'(cfg_ff.blend_mode);
         end
         hlb_pkg::REG_LAYER_OPACITY: begin
            csr_prdata = hlb_pkg::CSR_DATA_W'(cfg_ff.layer_opacity);
         end
         hlb_pkg::REG_MASK_ENABLE: begin
            csr_prdata = hlb_pkg::CSR_DATA_W'(cfg_ff.mask_enable);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_mode    <= hlb_pkg::BLEND_MODE_RESET;
         cfg_ff.layer_opacity <= hlb_pkg::LAYER_OPACITY_RESET;
         cfg_ff.mask_enable   <= hlb_pkg::MASK_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/hlb_datapath.sv =====
module hlb_datapath #(
   parameter int FRAC_BITS = hlb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hlb_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [hlb_pkg::SAMPLE_W-1:0]  in_base,
   input  logic [hlb_pkg::SAMPLE_W-1:0]  in_layer,
   input  logic [hlb_pkg::SAMPLE_W-1:0]  in_mask,
   input  logic                          in_last,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [hlb_pkg::SAMPLE_W-1:0]  out_height,
   output logic                          out_applied,
   output logic                          out_last
);

   localparam int F      = FRAC_BITS;
   localparam int SW     = hlb_pkg::SAMPLE_W;
   localparam int STAGES = 5;
   // effective opacity: opacity * mask >> F, or the raw 16-bit opacity
   localparam int OP_W   = (2 * SW - F > SW) ? 2 * SW - F : SW;
   localparam int MAXFS  = (F > SW) ? F : SW;
   localparam int D_W    = MAXFS + 3;
   localparam int P1_W   = 2 * D_W;
   localparam int T_W    = P1_W - F + 1;
   localparam int OMO_W  = ((OP_W > F + 1) ? OP_W : F + 1) + 2;
   localparam int PB_W   = SW + 1 + OMO_W;
   localparam int PT_W   = T_W + OP_W + 1;
   localparam int L_W    = ((PB_W > PT_W) ? PB_W : PT_W) + 1;
   localparam int S_W    = L_W - F + 1;
   localparam int R_W    = ((S_W > SW + 1) ? S_W : SW + 1) + 2;

   localparam logic signed [D_W-1:0]   ONE_D    = D_W'(64'd1 << F);
   localparam logic signed [D_W-1:0]   HALF_D   = D_W'(64'd1 << (F - 1));
   localparam logic        [2*SW:0]    HALF_OP  = (2 * SW + 1)'(64'd1 << (F - 1));
   localparam logic        [P1_W-1:0]  HALF_P   = P1_W'(64'd1 << (F - 1));
   localparam logic signed [T_W-1:0]   ONE_T    = T_W'(64'd1 << F);
   localparam logic signed [OMO_W-1:0] ONE_O    = OMO_W'(64'd1 << F);
   localparam logic        [L_W-1:0]   HALF_L   = L_W'(64'd1 << (F - 1));
   localparam logic signed [R_W-1:0]   ONE_R    = R_W'(64'd1 << F);
   localparam logic        [SW:0]      ONE_CHK  = (SW + 1)'(64'd1 << F);

   // pipeline control
   logic [STAGES-1:0] valid_ff, valid_in, stage_en;

   // stage 1: opacity-mask product and blend-target product
   logic [SW-1:0]          s1_base_ff, s1_layer_ff;
   logic                   s1_last_ff, s1_tinv_ff, tinv_in;
   logic [2*SW-1:0]        s1_oprod_ff, oprod_in;
   logic signed [P1_W-1:0] s1_p1_ff, p1_in;
   logic signed [D_W-1:0]  b_d, l_d, xa, xb;

   // stage 2: rounded opacity and blend target
   logic [SW-1:0]          s2_base_ff;
   logic                   s2_last_ff, s2_zero_ff, zero_in;
   logic [OP_W-1:0]        s2_op_ff, op_in;
   logic signed [T_W-1:0]  s2_t_ff, t_in, p1_r_pos, prod_r;
   logic [2*SW:0]          op_sum;
   logic [P1_W-1:0]        p1_mag, p1_rnd;
   logic                   p1_neg;

   // stage 3: lerp products
   logic [SW-1:0]          s3_base_ff;
   logic                   s3_last_ff, s3_zero_ff;
   logic signed [PB_W-1:0] s3_pb_ff, pb_in;
   logic signed [PT_W-1:0] s3_pt_ff, pt_in;
   logic signed [OMO_W-1:0] omo;
   logic signed [OP_W:0]   op_s;
   logic signed [SW:0]     b_s;

   // stage 4: rounded lerp or scaled layer
   logic [SW-1:0]          s4_base_ff;
   logic                   s4_last_ff, s4_zero_ff;
   logic signed [S_W-1:0]  s4_s_ff, s_in, s_pos;
   logic signed [L_W-1:0]  lsum;
   logic [L_W-1:0]         l_mag, l_rnd;
   logic                   l_neg, lerp_mode;

   // stage 5: combine, clamp, output register
   logic [SW-1:0]          out_height_ff, out_height_in;
   logic                   out_applied_ff, out_applied_in, out_last_ff;
   logic signed [R_W-1:0]  b_r, s_r, r_raw, r_cl;

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready = stage_en[0];

   assign lerp_mode = (cfg.blend_mode == hlb_pkg::MODE_NORMAL)
                   || (cfg.blend_mode == hlb_pkg::MODE_MULTIPLY)
                   || (cfg.blend_mode == hlb_pkg::MODE_SCREEN)
                   || (cfg.blend_mode == hlb_pkg::MODE_OVERLAY);

   // ---------------- stage 1 ----------------
   always_comb begin
      b_d     = D_W'(in_base);
      l_d     = D_W'(in_layer);
      xa      = '0;
      xb      = '0;
      tinv_in = 1'b0;
      unique case (cfg.blend_mode)
         hlb_pkg::MODE_MULTIPLY: begin
            xa = b_d;
            xb = l_d;
         end
         hlb_pkg::MODE_SCREEN: begin
            xa      = ONE_D - b_d;
            xb      = ONE_D - l_d;
            tinv_in = 1'b1;
         end
         hlb_pkg::MODE_OVERLAY: begin
            if (b_d < HALF_D) begin
               xa = b_d <<< 1;
               xb = l_d;
            end else begin
               xa      = (ONE_D - b_d) <<< 1;
               xb      = ONE_D - l_d;
               tinv_in = 1'b1;
            end
         end
         hlb_pkg::MODE_NORMAL, hlb_pkg::MODE_ADD, hlb_pkg::MODE_SUBTRACT,
         hlb_pkg::MODE_MAX, hlb_pkg::MODE_MIN: begin
         end
      endcase
      p1_in    = xa * xb;
      oprod_in = cfg.layer_opacity * in_mask;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_base_ff  <= in_base;
         s1_layer_ff <= in_layer;
         s1_last_ff  <= in_last;
         s1_tinv_ff  <= tinv_in;
         s1_oprod_ff <= oprod_in;
         s1_p1_ff    <= p1_in;
      end
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      op_sum = {1'b0, s1_oprod_ff} + HALF_OP;
      if (cfg.mask_enable) begin
         op_in = OP_W'(op_sum >> F);
      end else begin
         op_in = OP_W'(cfg.layer_opacity);
      end
      zero_in = (op_in == '0);

      // round half away from zero on the magnitude
      p1_neg   = s1_p1_ff[P1_W-1];
      p1_mag   = p1_neg ? P1_W'(-s1_p1_ff) : P1_W'(s1_p1_ff);
      p1_rnd   = (p1_mag + HALF_P) >> F;
      p1_r_pos = T_W'(p1_rnd);
      prod_r   = p1_neg ? -p1_r_pos : p1_r_pos;

      unique case (cfg.blend_mode)
         hlb_pkg::MODE_MULTIPLY, hlb_pkg::MODE_SCREEN, hlb_pkg::MODE_OVERLAY: begin
            t_in = s1_tinv_ff ? ONE_T - prod_r : prod_r;
         end
         hlb_pkg::MODE_NORMAL, hlb_pkg::MODE_ADD, hlb_pkg::MODE_SUBTRACT,
         hlb_pkg::MODE_MAX, hlb_pkg::MODE_MIN: begin
            t_in = T_W'(s1_layer_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_base_ff <= s1_base_ff;
         s2_last_ff <= s1_last_ff;
         s2_zero_ff <= zero_in;
         s2_op_ff   <= op_in;
         s2_t_ff    <= t_in;
      end
   end

   // ---------------- stage 3 ----------------
   always_comb begin
      op_s  = signed'({1'b0, s2_op_ff});
      omo   = ONE_O - signed'(OMO_W'(s2_op_ff));
      b_s   = signed'({1'b0, s2_base_ff});
      pb_in = b_s * omo;
      pt_in = s2_t_ff * op_s;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_base_ff <= s2_base_ff;
         s3_last_ff <= s2_last_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_pb_ff   <= pb_in;
         s3_pt_ff   <= pt_in;
      end
   end

   // ---------------- stage 4 ----------------
   always_comb begin
      if (lerp_mode) begin
         lsum = L_W'(s3_pb_ff) + L_W'(s3_pt_ff);
      end else begin
         lsum = L_W'(s3_pt_ff);
      end
      l_neg = lsum[L_W-1];
      l_mag = l_neg ? L_W'(-lsum) : L_W'(lsum);
      l_rnd = (l_mag + HALF_L) >> F;
      s_pos = S_W'(l_rnd);
      s_in  = l_neg ? -s_pos : s_pos;
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_base_ff <= s3_base_ff;
         s4_last_ff <= s3_last_ff;
         s4_zero_ff <= s3_zero_ff;
         s4_s_ff    <= s_in;
      end
   end

   // ---------------- stage 5 ----------------
   always_comb begin
      b_r = signed'(R_W'(s4_base_ff));
      s_r = R_W'(s4_s_ff);
      unique case (cfg.blend_mode)
         hlb_pkg::MODE_ADD: begin
            r_raw = b_r + s_r;
         end
         hlb_pkg::MODE_SUBTRACT: begin
            r_raw = b_r - s_r;
         end
         hlb_pkg::MODE_MAX: begin
            r_raw = (b_r > s_r) ? b_r : s_r;
         end
         hlb_pkg::MODE_MIN: begin
            r_raw = (b_r < s_r) ? b_r : s_r;
         end
         hlb_pkg::MODE_NORMAL, hlb_pkg::MODE_MULTIPLY, hlb_pkg::MODE_SCREEN,
         hlb_pkg::MODE_OVERLAY: begin
            r_raw = s_r;
         end
      endcase

      if (r_raw[R_W-1]) begin
         r_cl = '0;
      end else if (r_raw > ONE_R) begin
         r_cl = ONE_R;
      end else begin
         r_cl = r_raw;
      end

      // zero opacity passes the base through untouched
      if (s4_zero_ff) begin
         out_height_in  = s4_base_ff;
         out_applied_in = 1'b0;
      end else begin
         out_height_in  = r_cl[SW-1:0];
         out_applied_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         out_height_ff  <= out_height_in;
         out_applied_ff <= out_applied_in;
         out_last_ff    <= s4_last_ff;
      end
   end

   assign out_valid   = valid_ff[STAGES-1];
   assign out_height  = out_height_ff;
   assign out_applied = out_applied_ff;
   assign out_last    = out_last_ff;

`include "heightmap_layer_blend_macros.svh"

   `HLB_ASSERT_SAME(a_clamp_range, clock, reset, out_valid && out_applied, (F >= SW) || ({1'b0, out_height} <= ONE_CHK), "blended height above one")
   `HLB_ASSERT_SAME(a_full_stall_blocks_input, clock, reset, (&valid_ff) && !out_ready, !in_ready, "input taken while pipeline full and stalled")
   `HLB_ASSERT_NEXT(a_full_stall_holds, clock, reset, (&valid_ff) && !out_ready, &valid_ff, "pipeline lost an item during a stall")

endmodule

// ===== hdl/heightmap_layer_blend.sv =====
// channel   direction  transfer                        payload
// req       in         req_tvalid & req_tready         base, layer, mask samples; frame end
// rsp       out        rsp_tvalid & rsp_tready         blended height; applied flag; frame end
// csr       in         psel & penable & pwrite         blend mode, opacity, mask enable
//
// one pixel per cycle sustained while rsp_tready stays high; each req item passes through the
// five register stages in order before rsp_tvalid rises for it
// (mask scale, rounding, lerp multiply, rounding, clamp)
// synchronous active-high reset empties the pipeline and restores register defaults
// a stall on rsp holds the output stage while earlier stages close up any bubbles;
// req_tready falls only once all stages hold an item
module heightmap_layer_blend #(
   parameter int FRAC_BITS = hlb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [47:0]                     req_tdata,  // base_height, layer_height, mask_value
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // blended_height
   output logic [0:0]                      rsp_tuser,  // applied
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hlb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [hlb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [hlb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   hlb_pkg::cfg_type cfg;
   logic             applied;

   hlb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hlb_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_base     (req_tdata[15:0]),
      .in_layer    (req_tdata[31:16]),
      .in_mask     (req_tdata[47:32]),
      .in_last     (req_tlast),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_height  (rsp_tdata),
      .out_applied (applied),
      .out_last    (rsp_tlast)
   );

   assign rsp_tuser = applied;

endmodule
